>>> design/reassembly_context_table_macros.svh
// Assertion macros for the block's top RTL file.
`ifndef REASSEMBLY_CONTEXT_TABLE_MACROS_SVH
`define REASSEMBLY_CONTEXT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define RCT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("reassembly context table check failed");
`define RCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("reassembly context table check failed");
`else
`define RCT_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define RCT_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> design/rct_pkg.sv
package rct_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int BYTES_W   = 36;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [31:0] MAX_TOTAL_RESET   = 32'd1048576;
  localparam logic [3:0]  MAX_ENTRIES_RESET = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] KIND_HIT      = 3'd0;
  localparam logic [2:0] KIND_MISS     = 3'd1;
  localparam logic [2:0] KIND_EVICTED  = 3'd2;
  localparam logic [2:0] KIND_ADDED    = 3'd3;
  localparam logic [2:0] KIND_REMOVED  = 3'd4;
  localparam logic [2:0] KIND_BAD_SLOT = 3'd5;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] family;
    logic [31:0] seq;
    logic [31:0] bytes;
    logic [15:0] frags;
    logic [62:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic key_hit;
    logic older;
  } cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EV_CHECK,
    ST_EV_SCAN,
    ST_ADD,
    ST_RM_READ,
    ST_RM_MOVE
  } state_t;

endpackage

>>> design/rct_cmp.sv
module rct_cmp import rct_pkg::*; (
  input  entry_t      cand,
  input  entry_t      key,
  input  logic [62:0] ref_time,
  output cmp_t        res
);

  assign res.key_hit = (cand.addr == key.addr) && (cand.port == key.port) &&
                       (cand.family == key.family);
  assign res.older   = cand.tstamp < ref_time;

endmodule

>>> design/reassembly_context_table.sv
// Lookup: an empty table misses from idle, else slots are read in order up to a hit or
// the last entry. Add: while a limit is exceeded, a scan evicts the oldest entry; then
// the entry is appended. Remove: the last entry fills the slot; a bad slot is reported.
// A single slot memory read port and a shared key and age comparator: one slot per cycle.
// A new command is taken only while busy is low; results are never stalled.
// Synchronous active-low reset empties the table and restores both limit registers.
`include "reassembly_context_table_macros.svh"

module reassembly_context_table import rct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_src_addr,
  input  logic [15:0]          in_src_port,
  input  logic [15:0]          in_addr_family,
  input  logic [31:0]          in_msg_seq,
  input  logic [31:0]          in_msg_bytes,
  input  logic [15:0]          in_fragment_count,
  input  logic [62:0]          in_packet_time,
  input  logic [3:0]           in_slot_index,
  output logic                 out_strobe,
  output logic [2:0]           out_result_kind,
  output logic [3:0]           out_found_slot,
  output logic [31:0]          out_entry_addr,
  output logic [15:0]          out_entry_port,
  output logic [15:0]          out_entry_family,
  output logic [31:0]          out_entry_seq,
  output logic [31:0]          out_entry_bytes,
  output logic [15:0]          out_entry_fragments,
  output logic [62:0]          out_entry_time,
  output logic [35:0]          out_bytes_held,
  output logic [4:0]           out_entries_held,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  entry_t slot_mem [MAX_SLOTS];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               pv_r, pv_nxt;
  logic [SLOT_W-1:0]  pidx_r, pidx_nxt;
  entry_t             best_r, best_nxt;
  logic [SLOT_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  entry_t             new_r, new_nxt;
  logic [SLOT_W-1:0]  rm_slot_r, rm_slot_nxt;
  logic [31:0]        max_total_r;
  logic [3:0]         max_entries_r;
  entry_t             rd_data_r;

  logic [SLOT_W-1:0]  rd_addr;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;

  logic               emit;
  logic [2:0]         e_kind;
  logic [SLOT_W-1:0]  e_slot;
  entry_t             e_entry;
  logic [BYTES_W-1:0] e_bytes;
  logic [CNT_W-1:0]   e_count;
  logic               e_last;

  logic               out_strobe_r;
  logic [2:0]         out_kind_r;
  logic [SLOT_W-1:0]  out_slot_r;
  entry_t             out_entry_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_last_r;

  cmp_t               cmp;
  logic               issue_lt;
  logic [SLOT_W-1:0]  last_idx;
  logic               take;
  entry_t             sel_entry;
  logic [SLOT_W-1:0]  sel_idx;
  logic               evict_due;

  rct_cmp u_cmp (
    .cand     (rd_data_r),
    .key      (new_r),
    .ref_time (best_r.tstamp),
    .res      (cmp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_total_r   <= MAX_TOTAL_RESET;
      max_entries_r <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_TOTAL:   max_total_r   <= cfg_wdata[31:0];
        CFG_MAX_ENTRIES: max_entries_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_r      <= '0;
      pv_r         <= 1'b0;
      total_r      <= '0;
      bytes_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      pv_r         <= pv_nxt;
      total_r      <= total_nxt;
      bytes_r      <= bytes_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    new_r      <= new_nxt;
    rm_slot_r  <= rm_slot_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_slot_r  <= e_slot;
      out_entry_r <= e_entry;
      out_bytes_r <= e_bytes;
      out_count_r <= e_count;
      out_last_r  <= e_last;
    end
  end

  assign issue_lt  = issue_r < total_r;
  assign last_idx  = SLOT_W'(total_r - CNT_W'(1));
  assign take      = (pidx_r == '0) || cmp.older;
  assign sel_entry = take ? rd_data_r : best_r;
  assign sel_idx   = take ? pidx_r : best_idx_r;
  assign evict_due = (total_r != '0) &&
                     ((bytes_r > BYTES_W'(max_total_r)) ||
                      (total_r > CNT_W'(max_entries_r)) ||
                      (total_r >= CNT_W'(MAX_SLOTS)));

  always_comb begin
    state_nxt    = state_r;
    issue_nxt    = issue_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = issue_r[SLOT_W-1:0];
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    total_nxt    = total_r;
    bytes_nxt    = bytes_r;
    new_nxt      = new_r;
    rm_slot_nxt  = rm_slot_r;
    rd_addr      = issue_r[SLOT_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = best_idx_r;
    wr_data      = rd_data_r;
    emit         = 1'b0;
    e_kind       = KIND_MISS;
    e_slot       = '0;
    e_entry      = '0;
    e_bytes      = bytes_r;
    e_count      = total_r;
    e_last       = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          new_nxt     = '{addr: in_src_addr, port: in_src_port, family: in_addr_family,
                          seq: in_msg_seq, bytes: in_msg_bytes,
                          frags: in_fragment_count, tstamp: in_packet_time};
          rm_slot_nxt = in_slot_index;
          issue_nxt   = '0;
          unique case (in_command)
            CMD_LOOKUP: begin
              if (total_r == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = ST_LOOKUP;
              end
            end
            CMD_ADD: state_nxt = ST_EV_CHECK;
            CMD_REMOVE: begin
              if (CNT_W'(in_slot_index) >= total_r) begin
                emit   = 1'b1;
                e_kind = KIND_BAD_SLOT;
                e_slot = in_slot_index;
              end else begin
                rd_addr   = in_slot_index;
                state_nxt = ST_RM_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOKUP: begin
        if (issue_lt) begin
          pv_nxt    = 1'b1;
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (pv_r) begin
          if (cmp.key_hit) begin
            emit      = 1'b1;
            e_kind    = KIND_HIT;
            e_slot    = pidx_r;
            e_entry   = rd_data_r;
            pv_nxt    = 1'b0;
            state_nxt = ST_IDLE;
          end else if (pidx_r == last_idx) begin
            emit      = 1'b1;
            pv_nxt    = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EV_CHECK: begin
        issue_nxt = '0;
        state_nxt = evict_due ? ST_EV_SCAN : ST_ADD;
      end
      ST_EV_SCAN: begin
        if (issue_lt) begin
          pv_nxt    = 1'b1;
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (pv_r) begin
          best_nxt     = sel_entry;
          best_idx_nxt = sel_idx;
          if (pidx_r == last_idx) begin
            wr_en     = 1'b1;
            wr_addr   = sel_idx;
            wr_data   = rd_data_r;
            total_nxt = total_r - CNT_W'(1);
            bytes_nxt = bytes_r - BYTES_W'(sel_entry.bytes);
            emit      = 1'b1;
            e_kind    = KIND_EVICTED;
            e_slot    = sel_idx;
            e_entry   = sel_entry;
            e_bytes   = bytes_nxt;
            e_count   = total_nxt;
            e_last    = 1'b0;
            pv_nxt    = 1'b0;
            state_nxt = ST_EV_CHECK;
          end
        end
      end
      ST_ADD: begin
        wr_en     = 1'b1;
        wr_addr   = total_r[SLOT_W-1:0];
        wr_data   = new_r;
        total_nxt = total_r + CNT_W'(1);
        bytes_nxt = bytes_r + BYTES_W'(new_r.bytes);
        emit      = 1'b1;
        e_kind    = KIND_ADDED;
        e_slot    = total_r[SLOT_W-1:0];
        e_entry   = new_r;
        e_bytes   = bytes_nxt;
        e_count   = total_nxt;
        state_nxt = ST_IDLE;
      end
      ST_RM_READ: begin
        best_nxt  = rd_data_r;
        rd_addr   = last_idx;
        state_nxt = ST_RM_MOVE;
      end
      ST_RM_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = rm_slot_r;
        wr_data   = rd_data_r;
        total_nxt = total_r - CNT_W'(1);
        bytes_nxt = bytes_r - BYTES_W'(best_r.bytes);
        emit      = 1'b1;
        e_kind    = KIND_REMOVED;
        e_slot    = rm_slot_r;
        e_entry   = best_r;
        e_bytes   = bytes_nxt;
        e_count   = total_nxt;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy                = state_r != ST_IDLE;
  assign out_strobe          = out_strobe_r;
  assign out_result_kind     = out_kind_r;
  assign out_found_slot      = out_slot_r;
  assign out_entry_addr      = out_entry_r.addr;
  assign out_entry_port      = out_entry_r.port;
  assign out_entry_family    = out_entry_r.family;
  assign out_entry_seq       = out_entry_r.seq;
  assign out_entry_bytes     = out_entry_r.bytes;
  assign out_entry_fragments = out_entry_r.frags;
  assign out_entry_time      = out_entry_r.tstamp;
  assign out_bytes_held      = out_bytes_r;
  assign out_entries_held    = out_count_r;
  assign out_last            = out_last_r;

  `RCT_ASSERT_IMPL(a_only_evict_not_last, clk, rst_n,
                   out_strobe && !out_last, out_result_kind == KIND_EVICTED)
  `RCT_ASSERT_IMPL(a_added_is_top_slot, clk, rst_n,
                   out_strobe && out_result_kind == KIND_ADDED,
                   CNT_W'(out_found_slot) + CNT_W'(1) == out_entries_held)
  `RCT_ASSERT_NEXT(a_cmd_makes_progress, clk, rst_n,
                   start && !busy && in_command != CMD_NONE, busy || out_strobe)
  `RCT_ASSERT_IMPL(a_table_bounded, clk, rst_n,
                   out_strobe, out_entries_held <= CNT_W'(MAX_SLOTS))

endmodule

>>> dv/testbench.sv
module testbench;
  import rct_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    entry_t      ent;
    logic [35:0] bytes_held;
    logic [4:0]  entries_held;
    logic        last;
  } table_word_t;

  class context_table_scoreboard;
    entry_t      slots [MAX_SLOTS];
    int unsigned held;
    logic [35:0] bytes_total;
    logic [31:0] size_limit;
    logic [3:0]  count_limit;
    table_word_t expected_q [$];
    int          errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      held = 0;
      bytes_total = '0;
      size_limit = MAX_TOTAL_RESET;
      count_limit = MAX_ENTRIES_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_MAX_TOTAL) begin
        size_limit = value;
      end else if (idx == CFG_MAX_ENTRIES) begin
        count_limit = value[3:0];
      end
    endfunction

    function void expect_word(logic [2:0] kind, logic [3:0] slot, entry_t ent, logic last);
      table_word_t w;
      w.kind = kind;
      w.slot = slot;
      w.ent = ent;
      w.bytes_held = bytes_total;
      w.entries_held = held[4:0];
      w.last = last;
      expected_q.insert(expected_q.size(), w);
    endfunction

    // The last valid entry fills the hole left by the dropped one.
    function void drop_slot(int unsigned i);
      bytes_total = bytes_total - slots[i].bytes;
      slots[i] = slots[held - 1];
      held = held - 1;
    endfunction

    function void note_item(logic [1:0] cmd, entry_t item, logic [3:0] slot_idx);
      entry_t      victim;
      int unsigned best;
      logic [3:0]  pos;
      case (cmd)
        CMD_LOOKUP: begin
          for (int unsigned i = 0; i < held; i++) begin
            if (slots[i].addr == item.addr && slots[i].port == item.port &&
                slots[i].family == item.family) begin
              pos = i[3:0];
              expect_word(KIND_HIT, pos, slots[i], 1'b1);
              return;
            end
          end
          expect_word(KIND_MISS, 4'd0, '0, 1'b1);
        end
        CMD_ADD: begin
          while (held > 0 && (bytes_total > {4'd0, size_limit} || held > count_limit ||
                              held >= MAX_SLOTS)) begin
            best = 0;
            for (int unsigned i = 1; i < held; i++) begin
              if (slots[i].tstamp < slots[best].tstamp) best = i;
            end
            victim = slots[best];
            drop_slot(best);
            pos = best[3:0];
            expect_word(KIND_EVICTED, pos, victim, 1'b0);
          end
          pos = held[3:0];
          slots[held] = item;
          held = held + 1;
          bytes_total = bytes_total + item.bytes;
          expect_word(KIND_ADDED, pos, item, 1'b1);
        end
        CMD_REMOVE: begin
          if (slot_idx >= held) begin
            expect_word(KIND_BAD_SLOT, slot_idx, '0, 1'b1);
          end else begin
            victim = slots[slot_idx];
            drop_slot(32'(slot_idx));
            expect_word(KIND_REMOVED, slot_idx, victim, 1'b1);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(table_word_t got);
      table_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, kind %0h slot %0h", $time, got.kind, got.slot);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("result_kind", 64'(want.kind), 64'(got.kind));
      compare("found_slot", 64'(want.slot), 64'(got.slot));
      compare("entry_addr", 64'(want.ent.addr), 64'(got.ent.addr));
      compare("entry_port", 64'(want.ent.port), 64'(got.ent.port));
      compare("entry_family", 64'(want.ent.family), 64'(got.ent.family));
      compare("entry_seq", 64'(want.ent.seq), 64'(got.ent.seq));
      compare("entry_bytes", 64'(want.ent.bytes), 64'(got.ent.bytes));
      compare("entry_fragments", 64'(want.ent.frags), 64'(got.ent.frags));
      compare("entry_time", 64'(want.ent.tstamp), 64'(got.ent.tstamp));
      compare("bytes_held", 64'(want.bytes_held), 64'(got.bytes_held));
      compare("entries_held", 64'(want.entries_held), 64'(got.entries_held));
      compare("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_command;
  logic [31:0]          in_src_addr;
  logic [15:0]          in_src_port;
  logic [15:0]          in_addr_family;
  logic [31:0]          in_msg_seq;
  logic [31:0]          in_msg_bytes;
  logic [15:0]          in_fragment_count;
  logic [62:0]          in_packet_time;
  logic [3:0]           in_slot_index;
  logic                 out_strobe;
  logic [2:0]           out_result_kind;
  logic [3:0]           out_found_slot;
  logic [31:0]          out_entry_addr;
  logic [15:0]          out_entry_port;
  logic [15:0]          out_entry_family;
  logic [31:0]          out_entry_seq;
  logic [31:0]          out_entry_bytes;
  logic [15:0]          out_entry_fragments;
  logic [62:0]          out_entry_time;
  logic [35:0]          out_bytes_held;
  logic [4:0]           out_entries_held;
  logic                 out_last;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  context_table_scoreboard sb = new();
  entry_t                  key_pool [6];

  reassembly_context_table u_dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin : result_monitor
    table_word_t got;
    if (rst_n && out_strobe) begin
      got.kind = out_result_kind;
      got.slot = out_found_slot;
      got.ent.addr = out_entry_addr;
      got.ent.port = out_entry_port;
      got.ent.family = out_entry_family;
      got.ent.seq = out_entry_seq;
      got.ent.bytes = out_entry_bytes;
      got.ent.frags = out_entry_fragments;
      got.ent.tstamp = out_entry_time;
      got.bytes_held = out_bytes_held;
      got.entries_held = out_entries_held;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  function automatic entry_t make_entry(logic [31:0] addr, logic [15:0] port,
                                        logic [15:0] family, logic [31:0] seq,
                                        logic [31:0] bytes, logic [15:0] frags,
                                        logic [62:0] tstamp);
    entry_t e;
    e.addr = addr;
    e.port = port;
    e.family = family;
    e.seq = seq;
    e.bytes = bytes;
    e.frags = frags;
    e.tstamp = tstamp;
    return e;
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    int     r;
    int     k;
    e.addr = $urandom;
    e.port = 16'($urandom);
    e.family = 16'($urandom);
    e.seq = $urandom;
    e.frags = 16'($urandom);
    e.tstamp = {31'($urandom), 32'($urandom)};
    if ($urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, 5);
      e.addr = key_pool[k].addr;
      e.port = key_pool[k].port;
      e.family = key_pool[k].family;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      e.bytes = $urandom_range(0, 200000);
    end else if (r < 85) begin
      e.bytes = $urandom_range(0, 50);
    end else begin
      e.bytes = $urandom;
    end
    if ($urandom_range(0, 2) == 0) e.tstamp = 63'($urandom_range(0, 3));
    return e;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input entry_t item, input logic [3:0] slot);
    start <= 1'b1;
    in_command <= cmd;
    in_src_addr <= item.addr;
    in_src_port <= item.port;
    in_addr_family <= item.family;
    in_msg_seq <= item.seq;
    in_msg_bytes <= item.bytes;
    in_fragment_count <= item.frags;
    in_packet_time <= item.tstamp;
    in_slot_index <= slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(cmd, item, slot);
  endtask

  task automatic pause(input bit allow);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      n = 0;
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(10, 40);
    end
    if (allow && n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_limit(idx, value);
  endtask

  task automatic random_phase(input int count, input int add_pct);
    entry_t     item;
    logic [1:0] cmd;
    logic [3:0] slot;
    int         r;
    for (int i = 0; i < count; i++) begin
      item = random_entry();
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        cmd = CMD_ADD;
      end else if (r < add_pct + (100 - add_pct) / 2) begin
        cmd = CMD_LOOKUP;
      end else if (r < 96) begin
        cmd = CMD_REMOVE;
      end else begin
        cmd = CMD_NONE;
      end
      slot = 4'($urandom);
      if (cmd == CMD_REMOVE && sb.held > 0 && $urandom_range(0, 4) != 0) begin
        slot = 4'($urandom_range(0, sb.held - 1));
      end
      send_item(cmd, item, slot);
      pause((i % 30) >= 8);
    end
  endtask

  initial begin : stimulus
    entry_t zero_e;
    entry_t ones_e;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_LOOKUP;
    in_src_addr = '0;
    in_src_port = '0;
    in_addr_family = '0;
    in_msg_seq = '0;
    in_msg_bytes = '0;
    in_fragment_count = '0;
    in_packet_time = '0;
    in_slot_index = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_TOTAL;
    cfg_wdata = '0;
    foreach (key_pool[k]) key_pool[k] = make_entry($urandom, 16'($urandom), 16'($urandom),
                                                   '0, '0, '0, '0);
    key_pool[1].addr = key_pool[0].addr;
    key_pool[3].addr = key_pool[2].addr;
    key_pool[3].port = key_pool[2].port;
    zero_e = '0;
    ones_e = '1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_LOOKUP, zero_e, 4'd0);
    send_item(CMD_REMOVE, zero_e, 4'd0);
    pause(1'b1);
    send_item(CMD_REMOVE, ones_e, 4'd15);
    send_item(CMD_ADD, zero_e, 4'd0);
    send_item(CMD_ADD, ones_e, 4'd15);
    pause(1'b1);
    send_item(CMD_LOOKUP, zero_e, 4'd0);
    send_item(CMD_LOOKUP, ones_e, 4'd0);
    send_item(CMD_LOOKUP, make_entry('1, '0, '1, '0, '0, '0, '0), 4'd0);
    // The all-ones entry pushes the byte total over its limit, so this add empties the table.
    send_item(CMD_ADD, make_entry(32'h0a000001, 16'd5000, 16'd2, 32'd1, 32'd100, 16'd3, '0),
              4'd0);
    send_item(CMD_ADD, make_entry(32'h0a000002, 16'd5001, 16'd2, 32'd2, 32'd200, 16'd4, '0),
              4'd0);
    pause(1'b1);
    send_item(CMD_ADD, make_entry(32'h0a000003, 16'd5002, 16'd2, 32'd3, 32'd300, 16'd5, '0),
              4'd0);
    send_item(CMD_NONE, ones_e, 4'd15);
    send_item(CMD_REMOVE, zero_e, 4'd1);
    send_item(CMD_REMOVE, zero_e, 4'd5);
    send_item(CMD_LOOKUP, make_entry(32'h0a000003, 16'd5002, 16'd2, '0, '0, '0, '0), 4'd0);
    send_item(CMD_ADD, make_entry(32'h0a000001, 16'd5000, 16'd2, 32'd9, 32'd50, 16'd1, 63'd7),
              4'd0);
    send_item(CMD_LOOKUP, make_entry(32'h0a000001, 16'd5000, 16'd2, '0, '0, '0, '0), 4'd0);

    write_reg(CFG_MAX_TOTAL, '0);
    write_reg(CFG_MAX_ENTRIES, '0);
    send_item(CMD_ADD, make_entry(32'h0a000004, 16'd5003, 16'd2, 32'd4, 32'd10, 16'd2, '0),
              4'd0);
    random_phase(15, 50);

    write_reg(CFG_MAX_TOTAL, '1);
    write_reg(CFG_MAX_ENTRIES, 32'd15);
    random_phase(60, 70);

    write_reg(CFG_MAX_TOTAL, $urandom_range(1000, 400000));
    write_reg(CFG_MAX_ENTRIES, $urandom_range(1, 14));
    random_phase(45, 50);

    write_reg(CFG_MAX_TOTAL, MAX_TOTAL_RESET);
    write_reg(CFG_MAX_ENTRIES, 32'(MAX_ENTRIES_RESET));
    random_phase(31, 45);

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
